FILE: hdl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg
// Shared constants, codes and control structs of the sparse map parser.
// ----------------------------------------------------------------------------
package smp_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int BB_BITS     = $clog2(BLOCK_BYTES);
	localparam int BIB_W       = BB_BITS;
	localparam int MAX_EXTENTS = 32;
	localparam int IDX_W       = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CNT_W       = 6;
	localparam int VAL_W       = 48;
	localparam int BLK_W       = 16;
	localparam int NL_W        = 16;
	localparam int CFG_IDX_W   = 1;

	localparam logic [7:0] CHAR_NL = 8'd10;
	localparam logic [7:0] CHAR_0  = 8'h30;
	localparam logic [7:0] CHAR_9  = 8'h39;

	localparam logic [CFG_IDX_W-1:0] CFG_STORED_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REAL_SIZE   = 1'd1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_READ_ERR = 2'd2
	} status_t;

	typedef struct packed {
		logic in_en;
		logic chk_step;
		logic emit_step;
		logic err_emit;
	} dp_cmd_t;

	typedef struct packed {
		logic evt_fail;
		logic evt_finish;
		logic chk_bad;
		logic walk_last;
		logic slot_free;
	} dp_stat_t;

endpackage

FILE: hdl/smp_if.sv
// ----------------------------------------------------------------------------
// smp_if
// Channel interfaces: map byte input, result output, register writes.
// ----------------------------------------------------------------------------
interface smp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] map_byte;
	logic       start_of_map;
	logic       io_error;
	modport source (output valid, map_byte, start_of_map, io_error, input ready);
	modport sink   (input valid, map_byte, start_of_map, io_error, output ready);
endinterface

interface smp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [47:0] extent_logical_offset;
	logic [47:0] extent_stored_offset;
	logic [47:0] extent_length;
	logic        last;
	modport source (output valid, status, extent_logical_offset, extent_stored_offset,
		extent_length, last, input ready);
	modport sink   (input valid, status, extent_logical_offset, extent_stored_offset,
		extent_length, last, output ready);
endinterface

interface smp_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/smp_ctrl.sv
// ----------------------------------------------------------------------------
// smp_ctrl
// Sequencer: byte parsing, extent check walk, extent emission, error item.
// ----------------------------------------------------------------------------
module smp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  smp_pkg::dp_stat_t stat,
	output smp_pkg::dp_cmd_t  cmd
);
	import smp_pkg::*;

	typedef enum logic [3:0] {
		S_RUN   = 4'b0001,
		S_CHECK = 4'b0010,
		S_EMIT  = 4'b0100,
		S_FAIL  = 4'b1000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_RUN: begin
				cmd.in_en = 1'b1;
				if (stat.evt_fail) begin
					state_n = S_FAIL;
				end else if (stat.evt_finish) begin
					state_n = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.chk_step = 1'b1;
				if (stat.chk_bad) begin
					state_n = S_FAIL;
				end else if (stat.walk_last) begin
					state_n = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit_step = stat.slot_free;
				if (stat.slot_free && stat.walk_last) begin
					state_n = S_RUN;
				end
			end
			S_FAIL: begin
				cmd.err_emit = stat.slot_free;
				if (stat.slot_free) begin
					state_n = S_RUN;
				end
			end
			default: begin
				state_n = S_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
		end else begin
			state_q <= state_n;
		end
	end

	a_no_input_off_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_RUN) |-> !cmd.in_en)
		else $error("input taken outside parse state");

endmodule

FILE: hdl/smp_dp.sv
// ----------------------------------------------------------------------------
// smp_dp
// Datapath: parse registers, extent tables, check walk, output register.
// ----------------------------------------------------------------------------
module smp_dp (
	input  logic              clk,
	input  logic              arst_n,
	smp_in_if.sink            map_in,
	smp_out_if.source         res_out,
	smp_cfg_if.sink           cfg,
	input  smp_pkg::dp_cmd_t  cmd,
	output smp_pkg::dp_stat_t stat
);
	import smp_pkg::*;

	logic [VAL_W-1:0] stored_size_q, real_size_q;
	logic [BIB_W-1:0] bib_q, c_bib, n_bib;
	logic [BLK_W-1:0] br_q, c_br, n_br;
	logic [NL_W-1:0]  nl_q, c_nl, n_nl;
	logic             zero_q, c_zero, n_zero;
	logic [VAL_W-1:0] acc_q, c_acc, n_acc;
	logic             dig_q, c_dig, n_dig;
	logic             bad_q, c_bad, n_bad;
	logic             cok_q, c_cok, n_cok;
	logic [CNT_W-1:0] ec_q, c_ec, n_ec;
	logic             syn_q, c_syn, n_syn;
	logic             done_q, c_done, n_done;

	logic [VAL_W-1:0] tbl_off [MAX_EXTENTS];
	logic [VAL_W-1:0] tbl_len [MAX_EXTENTS];

	logic [CNT_W-1:0] walk_q;
	logic [VAL_W-1:0] soff_q, base_q, pend_q;
	status_t          err_q;

	logic             out_valid_q;
	status_t          o_status_q;
	logic [VAL_W-1:0] o_lo_q, o_so_q, o_len_q;
	logic             o_last_q;

	logic             in_fire, start, active, size_fail, parse_en, blk_done;
	logic             fail, finish, tbl_wr, good, is_digit;
	status_t          fail_code;
	logic [BLK_W:0]   br_inc;
	logic [VAL_W-1:0] blk_end, base_n;
	logic [VAL_W+3:0] acc_x10;
	logic [BIB_W:0]   bib_inc;
	logic [CNT_W:0]   lim_c, lim_n;
	logic [NL_W-1:0]  ln_m1;
	logic [IDX_W-1:0] wr_k;

	logic [VAL_W-1:0] e_off, e_len;
	logic [VAL_W:0]   s_plus, o_plus;
	logic             chk_bad, walk_last, slot_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_size_q <= '0;
			real_size_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_STORED_SIZE: stored_size_q <= cfg.data;
				CFG_REAL_SIZE:   real_size_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	assign map_in.ready = cmd.in_en;
	assign in_fire      = map_in.valid & map_in.ready;
	assign start        = map_in.start_of_map;

	assign c_bib  = start ? '0 : bib_q;
	assign c_br   = start ? '0 : br_q;
	assign c_nl   = start ? '0 : nl_q;
	assign c_zero = start ? 1'b0 : zero_q;
	assign c_acc  = start ? '0 : acc_q;
	assign c_dig  = start ? 1'b0 : dig_q;
	assign c_bad  = start ? 1'b0 : bad_q;
	assign c_cok  = start ? 1'b0 : cok_q;
	assign c_ec   = start ? '0 : ec_q;
	assign c_syn  = start ? 1'b0 : syn_q;
	assign c_done = start ? 1'b0 : done_q;

	assign active    = in_fire && !c_done;
	assign br_inc    = {1'b0, c_br} + 1'b1;
	assign blk_end   = VAL_W'({br_inc, {BB_BITS{1'b0}}});
	assign size_fail = (c_bib == '0) && (stored_size_q < blk_end);
	assign parse_en  = active && !size_fail && !map_in.io_error;

	assign is_digit = (map_in.map_byte >= CHAR_0) && (map_in.map_byte <= CHAR_9);
	assign acc_x10  = {1'b0, c_acc, 3'b000} + {3'b000, c_acc, 1'b0}
		+ (VAL_W+4)'(map_in.map_byte - CHAR_0);
	assign good     = c_dig && !c_bad;
	assign lim_c    = {c_ec, 1'b1};
	assign lim_n    = {n_ec, 1'b1};
	assign ln_m1    = c_nl - 1'b1;
	assign wr_k     = ln_m1[IDX_W:1];
	assign bib_inc  = {1'b0, c_bib} + 1'b1;
	assign blk_done = (bib_inc == (BIB_W+1)'(BLOCK_BYTES));

	always_comb begin
		n_bib  = c_bib;
		n_br   = c_br;
		n_nl   = c_nl;
		n_zero = c_zero;
		n_acc  = c_acc;
		n_dig  = c_dig;
		n_bad  = c_bad;
		n_cok  = c_cok;
		n_ec   = c_ec;
		n_syn  = c_syn;
		tbl_wr = 1'b0;
		if (parse_en) begin
			if (!c_zero) begin
				if (map_in.map_byte == 8'd0) begin
					n_zero = 1'b1;
				end else if (map_in.map_byte == CHAR_NL) begin
					if (c_nl == '0) begin
						if (good && c_acc >= VAL_W'(1) && c_acc <= VAL_W'(MAX_EXTENTS)) begin
							n_cok = 1'b1;
							n_ec  = CNT_W'(c_acc);
						end
					end else if (c_cok && (c_nl < NL_W'(lim_c))) begin
						if (!good) begin
							n_syn = 1'b1;
						end else begin
							tbl_wr = 1'b1;
						end
					end
					if (c_nl != '1) begin
						n_nl = c_nl + 1'b1;
					end
					n_acc = '0;
					n_dig = 1'b0;
					n_bad = 1'b0;
				end else if (is_digit) begin
					if (|acc_x10[VAL_W+3:VAL_W]) begin
						n_bad = 1'b1;
					end else begin
						n_acc = acc_x10[VAL_W-1:0];
					end
					n_dig = 1'b1;
				end else begin
					n_bad = 1'b1;
				end
			end
			if (blk_done) begin
				n_bib = '0;
				n_br  = br_inc[BLK_W-1:0];
			end else begin
				n_bib = bib_inc[BIB_W-1:0];
			end
		end
	end

	always_comb begin
		fail      = 1'b0;
		finish    = 1'b0;
		fail_code = ST_INVALID;
		if (active) begin
			if (size_fail) begin
				fail = 1'b1;
			end else if (map_in.io_error) begin
				fail      = 1'b1;
				fail_code = ST_READ_ERR;
			end else if (blk_done) begin
				if (c_br == '1 || !n_cok) begin
					fail = 1'b1;
				end else if (n_nl >= NL_W'(lim_n)) begin
					if (n_syn) begin
						fail = 1'b1;
					end else begin
						finish = 1'b1;
					end
				end
			end
		end
	end

	assign n_done = c_done | fail | finish;
	assign base_n = VAL_W'({n_br, {BB_BITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bib_q  <= '0;
			br_q   <= '0;
			nl_q   <= '0;
			zero_q <= 1'b0;
			acc_q  <= '0;
			dig_q  <= 1'b0;
			bad_q  <= 1'b0;
			cok_q  <= 1'b0;
			ec_q   <= '0;
			syn_q  <= 1'b0;
			done_q <= 1'b1;
		end else if (in_fire) begin
			bib_q  <= n_bib;
			br_q   <= n_br;
			nl_q   <= n_nl;
			zero_q <= n_zero;
			acc_q  <= n_acc;
			dig_q  <= n_dig;
			bad_q  <= n_bad;
			cok_q  <= n_cok;
			ec_q   <= n_ec;
			syn_q  <= n_syn;
			done_q <= n_done;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			if (ln_m1[0]) begin
				tbl_len[wr_k] <= c_acc;
			end else begin
				tbl_off[wr_k] <= c_acc;
			end
		end
	end

	assign e_off     = tbl_off[walk_q[IDX_W-1:0]];
	assign e_len     = tbl_len[walk_q[IDX_W-1:0]];
	assign s_plus    = {1'b0, soff_q} + {1'b0, e_len};
	assign o_plus    = {1'b0, e_off} + {1'b0, e_len};
	assign walk_last = (({1'b0, walk_q} + 1'b1) == {1'b0, ec_q});
	assign chk_bad   = ((e_len != '0) && ((soff_q[BB_BITS-1:0] != '0)
		|| (e_off[BB_BITS-1:0] != '0)))
		|| ((walk_q != '0) && (e_off < pend_q))
		|| (s_plus > {1'b0, stored_size_q})
		|| (o_plus > {1'b0, real_size_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
			err_q  <= ST_INVALID;
		end else begin
			if (fail) begin
				err_q <= fail_code;
			end
			if (finish) begin
				walk_q <= '0;
			end else if (cmd.chk_step) begin
				if (chk_bad) begin
					err_q <= ST_INVALID;
				end else if (walk_last) begin
					walk_q <= '0;
				end else begin
					walk_q <= walk_q + 1'b1;
				end
			end else if (cmd.emit_step) begin
				walk_q <= walk_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			soff_q <= base_n;
			base_q <= base_n;
		end else if (cmd.chk_step) begin
			if (walk_last) begin
				soff_q <= base_q;
			end else begin
				soff_q <= s_plus[VAL_W-1:0];
			end
			pend_q <= o_plus[VAL_W-1:0];
		end else if (cmd.emit_step) begin
			soff_q <= s_plus[VAL_W-1:0];
		end
	end

	assign slot_free = !out_valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_step || cmd.err_emit) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			o_status_q <= ST_OK;
			o_lo_q     <= e_off;
			o_so_q     <= soff_q;
			o_len_q    <= e_len;
			o_last_q   <= walk_last;
		end else if (cmd.err_emit) begin
			o_status_q <= err_q;
			o_lo_q     <= '0;
			o_so_q     <= '0;
			o_len_q    <= '0;
			o_last_q   <= 1'b1;
		end
	end

	assign res_out.valid                 = out_valid_q;
	assign res_out.status                = o_status_q;
	assign res_out.extent_logical_offset = o_lo_q;
	assign res_out.extent_stored_offset  = o_so_q;
	assign res_out.extent_length         = o_len_q;
	assign res_out.last                  = o_last_q;

	assign stat.evt_fail   = fail;
	assign stat.evt_finish = finish;
	assign stat.chk_bad    = chk_bad;
	assign stat.walk_last  = walk_last;
	assign stat.slot_free  = slot_free;

	a_fail_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		fail |=> done_q)
		else $error("map not closed after failure");

	a_finish_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (done_q && walk_q == '0))
		else $error("walk not rewound at map end");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_step || cmd.err_emit) |-> slot_free)
		else $error("output register overwritten");

endmodule

FILE: hdl/sparse_map_parser_top.sv
// ----------------------------------------------------------------------------
// sparse_map_parser_top
// Sparse archive map parser: decimal extent map in, checked extents out.
//
//   channel   dir  payload
//   map_in    in   map_byte[7:0], start_of_map, io_error
//   res_out   out  status[1:0], extent_logical_offset[47:0],
//                  extent_stored_offset[47:0], extent_length[47:0], last
//   cfg       in   index[0:0] (0 stored_size, 1 real_size), data[47:0]
//
// Map bytes are taken one per cycle while parsing.
// At the end of a complete map the extent table is checked one extent per
// cycle, then emitted one item per cycle while res_out is ready; input is
// held off for that time. An error item is loaded into the output register once it is free.
// Reset clears all control state; there is no clearing pass.
// ----------------------------------------------------------------------------
module sparse_map_parser_top (
	input  logic      clk,
	input  logic      arst_n,
	smp_in_if.sink    map_in,
	smp_out_if.source res_out,
	smp_cfg_if.sink   cfg
);
	import smp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	smp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	smp_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.map_in  (map_in),
		.res_out (res_out),
		.cfg     (cfg),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sparse map parser.
// Drives whole-block map texts (good maps, corrupted maps, read errors,
// zero bytes, aborted maps, idle noise) under several size settings and
// checks every result item against a cycle-free predictor of the parser.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import smp_pkg::*;

	localparam longint unsigned MAX48 = 64'hFFFF_FFFF_FFFF;

	typedef struct {
		bit [7:0] b;
		bit       som;
		bit       ioe;
	} map_item_t;

	typedef struct {
		status_t   st;
		bit [47:0] lo;
		bit [47:0] so;
		bit [47:0] len;
		bit        last;
	} extent_res_t;

	logic clk;
	logic arst_n;

	smp_in_if  mi();
	smp_out_if ro();
	smp_cfg_if cf();

	sparse_map_parser_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.map_in(mi),
		.res_out(ro),
		.cfg(cf)
	);

	map_item_t   byte_queue[$];
	extent_res_t expected_extents[$];
	int          errors;
	int          results_seen;
	int          maps_sent;
	bit          quiet;
	bit          in_taken;

	// predictor state
	longint unsigned p_stored, p_real;
	int unsigned     p_bib, p_blocks, p_nl, p_count;
	bit              p_zero, p_digits, p_bad, p_cok, p_serr, p_done;
	longint unsigned p_acc;
	longint unsigned p_offs[MAX_EXTENTS];
	longint unsigned p_lens[MAX_EXTENTS];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void parse_clear();
		p_bib = 0; p_blocks = 0; p_nl = 0; p_count = 0;
		p_zero = 0; p_digits = 0; p_bad = 0; p_cok = 0; p_serr = 0;
		p_acc = 0;
		for (int i = 0; i < MAX_EXTENTS; i++) begin
			p_offs[i] = 0;
			p_lens[i] = 0;
		end
	endfunction

	function automatic void push_error(status_t st);
		extent_res_t r;
		r.st = st; r.lo = 0; r.so = 0; r.len = 0; r.last = 1;
		expected_extents.push_back(r);
		p_done = 1;
	endfunction

	function automatic void close_line();
		bit          good;
		int unsigned k;
		good = p_digits && !p_bad;
		if (p_nl == 0) begin
			if (good && p_acc >= 1 && p_acc <= MAX_EXTENTS) begin
				p_cok = 1;
				p_count = 32'(p_acc);
			end
		end else if (p_cok && p_nl < 2 * p_count + 1) begin
			k = (p_nl - 1) / 2;
			if (!good)
				p_serr = 1;
			else if (k < MAX_EXTENTS) begin
				if ((p_nl - 1) & 1)
					p_lens[k] = p_acc;
				else
					p_offs[k] = p_acc;
			end
		end
		if (p_nl < 16'hFFFF)
			p_nl++;
		p_acc = 0;
		p_digits = 0;
		p_bad = 0;
	endfunction

	function automatic void emit_extents();
		longint unsigned base, psum, lend, o, l, s;
		extent_res_t     walk[$];
		extent_res_t     r;
		base = longint'(p_blocks) * BLOCK_BYTES;
		psum = 0;
		lend = 0;
		if (p_serr) begin
			push_error(ST_INVALID);
			return;
		end
		for (int i = 0; i < p_count && i < MAX_EXTENTS; i++) begin
			o = p_offs[i];
			l = p_lens[i];
			s = base + psum;
			if ((l != 0 && (s % BLOCK_BYTES != 0 || o % BLOCK_BYTES != 0)) ||
				(i > 0 && o < lend) || s + l > p_stored || o + l > p_real) begin
				push_error(ST_INVALID);
				return;
			end
			r.st = ST_OK; r.lo = o[47:0]; r.so = s[47:0]; r.len = l[47:0];
			r.last = (i + 1 == p_count);
			walk.push_back(r);
			psum += l;
			lend = o + l;
		end
		foreach (walk[i])
			expected_extents.push_back(walk[i]);
		p_done = 1;
	endfunction

	function automatic void predict_byte(map_item_t it);
		longint unsigned d;
		if (it.som) begin
			parse_clear();
			p_done = 0;
		end
		if (p_done)
			return;
		if (p_bib == 0 && p_stored < (longint'(p_blocks) + 1) * BLOCK_BYTES) begin
			push_error(ST_INVALID);
			return;
		end
		if (it.ioe) begin
			push_error(ST_READ_ERR);
			return;
		end
		if (!p_zero) begin
			if (it.b == 0)
				p_zero = 1;
			else if (it.b == CHAR_NL)
				close_line();
			else if (it.b >= CHAR_0 && it.b <= CHAR_9) begin
				d = 64'(it.b) - 64'(CHAR_0);
				if (p_acc > (MAX48 - d) / 10)
					p_bad = 1;
				else
					p_acc = p_acc * 10 + d;
				p_digits = 1;
			end else
				p_bad = 1;
		end
		p_bib++;
		if (p_bib < BLOCK_BYTES)
			return;
		p_bib = 0;
		if (p_blocks >= 16'hFFFF) begin
			push_error(ST_INVALID);
			return;
		end
		p_blocks++;
		if (!p_cok) begin
			push_error(ST_INVALID);
			return;
		end
		if (p_nl < 2 * p_count + 1)
			return;
		emit_extents();
	endfunction

	// map byte driver
	always @(negedge clk) begin
		map_item_t it;
		if (arst_n && (!mi.valid || in_taken)) begin
			if (byte_queue.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
				it = byte_queue.pop_front();
				mi.valid        <= 1'b1;
				mi.map_byte     <= it.b;
				mi.start_of_map <= it.som;
				mi.io_error     <= it.ioe;
			end else
				mi.valid <= 1'b0;
		end
		ro.ready <= quiet || $urandom_range(99) >= 7;
	end

	always @(posedge clk) begin
		map_item_t   it;
		extent_res_t e;
		in_taken = mi.valid && mi.ready;
		if (in_taken) begin
			it.b = mi.map_byte; it.som = mi.start_of_map; it.ioe = mi.io_error;
			predict_byte(it);
		end
		if (arst_n && ro.valid && ro.ready) begin
			results_seen++;
			if (expected_extents.size() == 0) begin
				$error("unexpected result item, status %0d", ro.status);
				errors++;
			end else begin
				e = expected_extents.pop_front();
				if (ro.status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, ro.status);
					errors++;
				end
				if (ro.extent_logical_offset !== e.lo) begin
					$error("extent_logical_offset: expected %0d, got %0d", e.lo,
						ro.extent_logical_offset);
					errors++;
				end
				if (ro.extent_stored_offset !== e.so) begin
					$error("extent_stored_offset: expected %0d, got %0d", e.so,
						ro.extent_stored_offset);
					errors++;
				end
				if (ro.extent_length !== e.len) begin
					$error("extent_length: expected %0d, got %0d", e.len, ro.extent_length);
					errors++;
				end
				if (ro.last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, ro.last);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [0:0] idx, longint unsigned val);
		@(negedge clk);
		cf.valid <= 1'b1;
		cf.index <= idx;
		cf.data  <= val[47:0];
		do @(posedge clk); while (!cf.ready);
		if (idx == CFG_STORED_SIZE)
			p_stored = val;
		else
			p_real = val;
		@(negedge clk);
		cf.valid <= 1'b0;
	endtask

	task automatic drain();
		while (byte_queue.size() > 0 || mi.valid)
			@(posedge clk);
		while (expected_extents.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_sizes(longint unsigned st, longint unsigned rl);
		drain();
		write_reg(CFG_STORED_SIZE, st);
		write_reg(CFG_REAL_SIZE, rl);
	endtask

	// pad: 0 zeros, 1 random bytes, 2 digits and newlines
	task automatic send_map(string txt, int nblk, int pad, int err_at, bit som = 1);
		map_item_t it;
		int        total;
		if (nblk == 0)
			nblk = (txt.len() + BLOCK_BYTES) / BLOCK_BYTES;
		total = nblk * BLOCK_BYTES;
		for (int i = 0; i < total; i++) begin
			if (i < txt.len())
				it.b = txt[i];
			else if (pad == 0)
				it.b = 0;
			else if (pad == 1)
				it.b = 8'($urandom_range(255));
			else
				it.b = ($urandom_range(3) == 0) ? CHAR_NL : 8'(CHAR_0 + $urandom_range(9));
			it.som = som && (i == 0);
			it.ioe = (i == err_at);
			byte_queue.push_back(it);
		end
		maps_sent++;
	endtask

	task automatic idle_noise(int n);
		map_item_t it;
		for (int i = 0; i < n; i++) begin
			it.b = 8'($urandom_range(255));
			it.som = 0;
			it.ioe = 1'($urandom_range(1));
			byte_queue.push_back(it);
		end
	endtask

	function automatic string map_text(int cnt, bit wide, int fault);
		string           s;
		longint unsigned o, l;
		s = $sformatf("%0d\n", cnt);
		o = wide ? {$urandom_range(32'h3FFF), $urandom()} & ~64'h1FF : 0;
		for (int i = 0; i < cnt; i++) begin
			o += $urandom_range(4) * BLOCK_BYTES;
			l = wide ? ({$urandom_range(255), $urandom()} & ~64'h1FF)
				: $urandom_range(8) * BLOCK_BYTES;
			if (fault == 1 && i == cnt - 1)
				o += 1;
			if (fault == 2 && i == cnt - 1 && i > 0)
				o = 0;
			s = {s, $sformatf("%0d\n%0d\n", o, l)};
			o += l;
		end
		return s;
	endfunction

	initial begin
		string s;
		int    k, cnt, pos;
		arst_n = 0;
		quiet = 0;
		errors = 0; results_seen = 0; maps_sent = 0;
		mi.valid = 0; mi.map_byte = 0; mi.start_of_map = 0; mi.io_error = 0;
		ro.ready = 0;
		cf.valid = 0; cf.index = CFG_STORED_SIZE; cf.data = 0;
		p_stored = 0; p_real = 0; p_done = 1;
		parse_clear();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// sizes zero: everything fails the size check
		set_sizes(0, 0);
		idle_noise(8);
		send_map("1\n0\n0\n", 1, 0, -1);

		set_sizes(MAX48, MAX48);
		send_map("1\n0\n0\n", 1, 0, -1);
		send_map(map_text(32, 1, 0), 0, 0, -1);
		send_map({"1\n0\n", $sformatf("%0d\n", MAX48)}, 1, 0, -1);
		send_map("0\n", 1, 0, -1);
		send_map("33\n", 1, 0, -1);
		send_map("2x\n", 1, 0, -1);
		send_map("2\n0\n\n512\n512\n", 1, 0, -1);
		send_map("1\n999999999999999999\n512\n", 1, 0, -1);
		send_map("2\n0\n512\n1024\n512\n", 1, 0, 300);
		s = "";
		for (int i = 0; i < 600; i++)
			s = {s, "0"};
		send_map({s, "1\n0\n0\n"}, 2, 0, -1);
		send_map(map_text(2, 0, 1), 1, 0, -1);
		send_map(map_text(3, 0, 2), 1, 0, -1);
		send_map({map_text(2, 0, 0), "77\n5\n"}, 1, 2, -1);
		send_map("2\n0\n512\n", 1, 0, -1, 1);
		send_map(map_text(1, 0, 0), 1, 1, -1);

		// small sizes: zero byte stalls the map until the size check ends it
		set_sizes(3 * BLOCK_BYTES, 1 << 20);
		send_map({"2\n0\n", 8'h00, "512\n"}, 4, 1, -1);
		send_map(map_text(3, 0, 0), 1, 0, -1);
		send_map(map_text(4, 0, 0), 2, 0, -1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_sizes(MAX48, MAX48);
				1: set_sizes(MAX48, $urandom_range(1 << 16, 1 << 20));
				2: set_sizes($urandom_range(2 * BLOCK_BYTES, 12 * BLOCK_BYTES), MAX48);
				default: set_sizes(MAX48, MAX48);
			endcase
			quiet = (ph == 3);
			for (int m = 0; m < 8; m++) begin
				cnt = $urandom_range(1, MAX_EXTENTS);
				if ($urandom_range(3) == 0)
					cnt = $urandom_range(1, 3);
				s = map_text(cnt, ph != 1 && $urandom_range(1), $urandom_range(9) == 0);
				k = $urandom_range(9);
				if (k == 0) begin
					pos = $urandom_range(s.len() - 1);
					s[pos] = 8'($urandom_range(255));
				end
				if (k == 1)
					idle_noise($urandom_range(1, 5));
				if (k == 2)
					send_map(s.substr(0, s.len() / 2), 1, 1, -1);
				send_map(s, $urandom_range(1) ? 0 : (s.len() / BLOCK_BYTES + 2),
					$urandom_range(2), (k == 3) ? $urandom_range(BLOCK_BYTES - 1) : -1);
			end
		end
		quiet = 0;
		drain();
		$display("Sent %0d maps under several size settings; checked %0d result items.",
			maps_sent, results_seen);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
hdl/smp_pkg.sv
hdl/smp_if.sv
hdl/smp_ctrl.sv
hdl/smp_dp.sv
hdl/sparse_map_parser_top.sv
tb/tb.sv
